[rtl/priority_task_queue_dedup_macros.svh]
// Assertion helpers shared by the queue RTL.
`ifndef PRIORITY_TASK_QUEUE_DEDUP_MACROS_SVH
`define PRIORITY_TASK_QUEUE_DEDUP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptqd_pkg.sv]
package ptqd_pkg;

    localparam int QUEUE_CAPACITY_DEF = 32;

    localparam int TAG_W    = 16;
    localparam int KEY_W    = 16;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_SUBMIT_TIMER = 3'd0,
        REQ_SUBMIT_TOUCH = 3'd1,
        REQ_TAKE         = 3'd2,
        REQ_START        = 3'd3,
        REQ_STOP         = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_STOPPED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_TAKE = 3'b100
    } t_state;

endpackage

[rtl/ptqd_step_unit.sv]
// Shared step unit: ring slot of head + offset, and a key compare.
module ptqd_step_unit
    import ptqd_pkg::*;
#(
    parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF,
    localparam int PTR_W = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1
) (
    input  logic [PTR_W-1:0] i_head,
    input  logic [PTR_W-1:0] i_offset,
    input  logic [KEY_W-1:0] i_key_a,
    input  logic [KEY_W-1:0] i_key_b,
    output logic [PTR_W-1:0] o_slot,
    output logic             o_key_eq
);

    localparam logic [PTR_W:0] CAP = (PTR_W+1)'(QUEUE_CAPACITY);

    logic [PTR_W:0] sum;
    logic [PTR_W:0] wrapped;

    // Both operands stay below the capacity, so one subtract folds the sum.
    assign sum     = {1'b0, i_head} + {1'b0, i_offset};
    assign wrapped = (sum >= CAP) ? (sum - CAP) : sum;
    assign o_slot  = wrapped[PTR_W-1:0];

    assign o_key_eq = (i_key_a == i_key_b);

endmodule

[rtl/priority_task_queue_dedup.sv]
// Channel   Dir  tdata                          tuser
// s (req)   in   [15:0] task_tag [31:16] key    [2:0] req_type
// m (rsp)   out  [15:0] take_tag [31:16] key    [1:0] status [2] take_valid
//                                               [3] take_from_timer
//
// Timer submit, start, stop, a take on empty queues and a refusal that needs
// no key scan answer in the cycle after acceptance. A take that finds a task
// answers via S_TAKE (registered read of the queue memory). A touch submit
// answers after its key scan: the shared step unit walks the waiting keys
// one per cycle through the touch memory read port. One request is in work
// at a time. Reset is synchronous and clears counts, heads and run state;
// no clearing pass runs over the memories. A stalled response holds the block.
module priority_task_queue_dedup
    import ptqd_pkg::*;
#(
    parameter int QUEUE_CAPACITY = QUEUE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] task_tag, [31:16] touch_key
    input  logic [2:0]  i_s_tuser,   // [2:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] take_tag, [31:16] take_key
    output logic [3:0]  o_m_tuser    // [1:0] status, [2] take_valid, [3] take_from_timer
);

    localparam int PTR_W = (QUEUE_CAPACITY > 1) ? $clog2(QUEUE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(QUEUE_CAPACITY + 1);
    localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W+1)'(QUEUE_CAPACITY);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_CAPACITY - 1);

    // Queue memories: one entry per slot, each queue may fill the capacity.
    logic [TAG_W-1:0]       timer_mem [QUEUE_CAPACITY];
    logic [KEY_W+TAG_W-1:0] touch_mem [QUEUE_CAPACITY];

    t_state           r_state, n_state;
    logic             r_running, n_running;
    logic [CNT_W-1:0] r_timer_cnt, n_timer_cnt;
    logic [CNT_W-1:0] r_touch_cnt, n_touch_cnt;
    logic [PTR_W-1:0] r_timer_head, n_timer_head;
    logic [PTR_W-1:0] r_touch_head, n_touch_head;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic             r_pend, n_pend;
    logic             r_take_timer, n_take_timer;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic [KEY_W-1:0] r_key, n_key;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic             r_take_valid, n_take_valid;
    logic [TAG_W-1:0] r_take_tag, n_take_tag;
    logic [KEY_W-1:0] r_take_key, n_take_key;
    logic             r_from_timer, n_from_timer;

    logic [TAG_W-1:0]       r_timer_rd;
    logic [KEY_W+TAG_W-1:0] r_touch_rd;

    logic             s_acc;
    logic             m_acc;
    t_req_type        req;
    logic             full;
    logic             scan_issue;
    logic             hit;
    logic [PTR_W-1:0] unit_head;
    logic [PTR_W-1:0] unit_offset;
    logic [PTR_W-1:0] slot;
    logic             key_eq;
    logic             timer_we;
    logic             touch_we;
    logic [PTR_W-1:0] touch_rd_addr;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = r_out_valid && i_m_tready;
    assign req   = t_req_type'(i_s_tuser);

    // Accept only from idle, and only when the response register can take a result.
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);

    assign full = ({1'b0, r_timer_cnt} + {1'b0, r_touch_cnt}) >= CAP_SUM;

    // While scanning, walk the touch ring; otherwise address the timer tail.
    assign scan_issue  = (r_issue != r_touch_cnt);
    assign unit_head   = (r_state == S_SCAN) ? r_touch_head : r_timer_head;
    assign unit_offset = (r_state != S_SCAN) ? r_timer_cnt[PTR_W-1:0] :
                         scan_issue          ? r_issue[PTR_W-1:0]     :
                                               r_touch_cnt[PTR_W-1:0];

    ptqd_step_unit #(
        .QUEUE_CAPACITY (QUEUE_CAPACITY)
    ) u_step (
        .i_head   (unit_head),
        .i_offset (unit_offset),
        .i_key_a  (r_touch_rd[KEY_W+TAG_W-1:TAG_W]),
        .i_key_b  (r_key),
        .o_slot   (slot),
        .o_key_eq (key_eq)
    );

    assign hit           = r_pend && key_eq;
    assign touch_rd_addr = (r_state == S_SCAN) ? slot : r_touch_head;

    always_comb begin
        n_state      = r_state;
        n_running    = r_running;
        n_timer_cnt  = r_timer_cnt;
        n_touch_cnt  = r_touch_cnt;
        n_timer_head = r_timer_head;
        n_touch_head = r_touch_head;
        n_issue      = r_issue;
        n_pend       = 1'b0;
        n_take_timer = r_take_timer;
        n_tag        = r_tag;
        n_key        = r_key;
        n_out_valid  = r_out_valid && !m_acc;
        n_status     = r_status;
        n_take_valid = r_take_valid;
        n_take_tag   = r_take_tag;
        n_take_key   = r_take_key;
        n_from_timer = r_from_timer;
        timer_we     = 1'b0;
        touch_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    // Default response: accepted, no task returned.
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    n_take_valid = 1'b0;
                    n_take_tag   = '0;
                    n_take_key   = '0;
                    n_from_timer = 1'b0;
                    n_tag        = i_s_tdata[TAG_W-1:0];
                    n_key        = i_s_tdata[KEY_W+TAG_W-1:TAG_W];
                    unique case (req)
                        REQ_SUBMIT_TIMER: begin
                            if (!r_running) begin
                                n_status = ST_STOPPED;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                timer_we    = 1'b1;
                                n_timer_cnt = r_timer_cnt + 1'b1;
                            end
                        end
                        REQ_SUBMIT_TOUCH: begin
                            if (!r_running) begin
                                n_status = ST_STOPPED;
                            end else begin
                                // Hold the response until the key scan ends.
                                n_out_valid = 1'b0;
                                n_issue     = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        REQ_TAKE: begin
                            if (!r_running) begin
                                n_status = ST_STOPPED;
                            end else if (r_timer_cnt != '0) begin
                                n_out_valid  = 1'b0;
                                n_take_timer = 1'b1;
                                n_timer_cnt  = r_timer_cnt - 1'b1;
                                n_timer_head = (r_timer_head == LAST_PTR) ? '0 :
                                               r_timer_head + 1'b1;
                                n_state      = S_TAKE;
                            end else if (r_touch_cnt != '0) begin
                                n_out_valid  = 1'b0;
                                n_take_timer = 1'b0;
                                n_touch_cnt  = r_touch_cnt - 1'b1;
                                n_touch_head = (r_touch_head == LAST_PTR) ? '0 :
                                               r_touch_head + 1'b1;
                                n_state      = S_TAKE;
                            end
                        end
                        REQ_START: begin
                            n_running = 1'b1;
                        end
                        REQ_STOP: begin
                            // Flush both queues on a running-to-stopped edge.
                            if (r_running) begin
                                n_running    = 1'b0;
                                n_timer_cnt  = '0;
                                n_touch_cnt  = '0;
                                n_timer_head = '0;
                                n_touch_head = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one key read a cycle; compare the previous read.
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DUP;
                    n_state     = S_IDLE;
                end else if (!scan_issue) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        touch_we    = 1'b1;
                        n_touch_cnt = r_touch_cnt + 1'b1;
                    end
                end else begin
                    n_pend  = 1'b1;
                    n_issue = r_issue + 1'b1;
                end
            end
            S_TAKE: begin
                n_out_valid  = 1'b1;
                n_take_valid = 1'b1;
                n_from_timer = r_take_timer;
                n_take_tag   = r_take_timer ? r_timer_rd : r_touch_rd[TAG_W-1:0];
                n_take_key   = r_take_timer ? '0 : r_touch_rd[KEY_W+TAG_W-1:TAG_W];
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memories: one write and one registered read per cycle each.
    // A timer submit writes in its accepting cycle, so take the tag off the bus.
    always_ff @(posedge i_clk) begin
        if (timer_we) begin
            timer_mem[slot] <= i_s_tdata[TAG_W-1:0];
        end
        r_timer_rd <= timer_mem[r_timer_head];
    end

    always_ff @(posedge i_clk) begin
        if (touch_we) begin
            touch_mem[slot] <= {r_key, r_tag};
        end
        r_touch_rd <= touch_mem[touch_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_running    <= 1'b0;
            r_timer_cnt  <= '0;
            r_touch_cnt  <= '0;
            r_timer_head <= '0;
            r_touch_head <= '0;
            r_issue      <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_running    <= n_running;
            r_timer_cnt  <= n_timer_cnt;
            r_touch_cnt  <= n_touch_cnt;
            r_timer_head <= n_timer_head;
            r_touch_head <= n_touch_head;
            r_issue      <= n_issue;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_take_timer <= n_take_timer;
        r_tag        <= n_tag;
        r_key        <= n_key;
        r_status     <= n_status;
        r_take_valid <= n_take_valid;
        r_take_tag   <= n_take_tag;
        r_take_key   <= n_take_key;
        r_from_timer <= n_from_timer;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_take_key, r_take_tag};
    assign o_m_tuser  = {r_from_timer, r_take_valid, r_status};

`include "priority_task_queue_dedup_macros.svh"

    `PTQD_ASSERT_NOW(a_cap, 1'b1, !full || (({1'b0, r_timer_cnt} + {1'b0, r_touch_cnt}) == CAP_SUM), "queues hold more than the capacity")
    `PTQD_ASSERT_NOW(a_busy_no_rsp, r_state != S_IDLE, !r_out_valid, "response pending while a request is in work")
    `PTQD_ASSERT_NEXT(a_take_done, r_state == S_TAKE, r_out_valid && r_take_valid, "take did not return its task")
    `PTQD_ASSERT_NEXT(a_stop_flush, s_acc && req == REQ_STOP, r_timer_cnt == '0 && r_touch_cnt == '0 && !r_running, "stop left tasks queued")
    `PTQD_ASSERT_NOW(a_scan_range, r_state == S_SCAN, r_issue <= r_touch_cnt, "key scan ran past the queue")

endmodule

[sim/ptqd_response_checker.sv]
module ptqd_response_checker
    import ptqd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [31:0] i_req_tdata,   // [15:0] task_tag, [31:16] touch_key
    input  logic [2:0]  i_req_tuser,   // [2:0] req_type
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [31:0] i_rsp_tdata,   // [15:0] take_tag, [31:16] take_key
    input  logic [3:0]  i_rsp_tuser,   // [1:0] status, [2] take_valid, [3] take_from_timer
    output int          o_fail_count,
    output int          o_outstanding
);

    localparam int DEPTH       = QUEUE_CAPACITY_DEF;
    localparam int PRINT_LIMIT = 40;
    localparam int RSP_DEPTH   = 8;

    typedef struct packed {
        t_status          status;
        logic             take_valid;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             from_timer;
    } t_response;

    // Shadow copy of both task queues.
    logic [TAG_W-1:0] timer_tags [DEPTH];
    logic [TAG_W-1:0] touch_tags [DEPTH];
    logic [KEY_W-1:0] touch_keys [DEPTH];
    int               timer_cnt  = 0;
    int               touch_cnt  = 0;
    int               timer_head = 0;
    int               touch_head = 0;
    bit               running    = 1'b0;

    // Ring of predicted responses, oldest at rsp_rd.
    t_response        expected_rsp [RSP_DEPTH];
    int               rsp_wr   = 0;
    int               rsp_rd   = 0;
    int               fail_cnt = 0;

    function automatic int wrap_slot(input int head, input int offset);
        return (head + offset) % DEPTH;
    endfunction

    function automatic bit key_is_waiting(input logic [KEY_W-1:0] key);
        for (int i = 0; i < touch_cnt; i++) begin
            if (touch_keys[wrap_slot(touch_head, i)] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_queues();
        timer_cnt  = 0;
        touch_cnt  = 0;
        timer_head = 0;
        touch_head = 0;
    endfunction

    // Apply one request to the shadow queues and return the response it causes.
    function automatic t_response predict_response(input logic [REQ_W-1:0] req,
                                                   input logic [TAG_W-1:0] tag,
                                                   input logic [KEY_W-1:0] key);
        t_response rsp;
        bit        full;
        rsp  = '0;
        full = (timer_cnt + touch_cnt) >= DEPTH;
        case (req)
            REQ_SUBMIT_TIMER: begin
                if (!running) rsp.status = ST_STOPPED;
                else if (full) rsp.status = ST_FULL;
                else begin
                    timer_tags[wrap_slot(timer_head, timer_cnt)] = tag;
                    timer_cnt++;
                end
            end
            REQ_SUBMIT_TOUCH: begin
                // duplicate key wins over a full queue
                if (!running) rsp.status = ST_STOPPED;
                else if (key_is_waiting(key)) rsp.status = ST_DUP;
                else if (full) rsp.status = ST_FULL;
                else begin
                    touch_tags[wrap_slot(touch_head, touch_cnt)] = tag;
                    touch_keys[wrap_slot(touch_head, touch_cnt)] = key;
                    touch_cnt++;
                end
            end
            REQ_TAKE: begin
                if (!running) rsp.status = ST_STOPPED;
                else if (timer_cnt > 0) begin
                    rsp.take_valid = 1'b1;
                    rsp.from_timer = 1'b1;
                    rsp.tag        = timer_tags[timer_head];
                    timer_head     = wrap_slot(timer_head, 1);
                    timer_cnt--;
                end else if (touch_cnt > 0) begin
                    rsp.take_valid = 1'b1;
                    rsp.tag        = touch_tags[touch_head];
                    rsp.key        = touch_keys[touch_head];
                    touch_head     = wrap_slot(touch_head, 1);
                    touch_cnt--;
                end
            end
            REQ_START: running = 1'b1;
            REQ_STOP: begin
                if (running) begin
                    running = 1'b0;
                    clear_queues();
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_cnt < PRINT_LIMIT) begin
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            running = 1'b0;
            clear_queues();
            rsp_wr = 0;
            rsp_rd = 0;
        end else begin
            // responses first: a response never belongs to a request of the same edge
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (rsp_wr == rsp_rd) begin
                    report_mismatch("response with no request outstanding",
                                    i_rsp_tuser, 0);
                end else begin
                    want = expected_rsp[rsp_rd % RSP_DEPTH];
                    rsp_rd++;
                    if (i_rsp_tuser[1:0] != want.status)
                        report_mismatch("status", i_rsp_tuser[1:0], want.status);
                    if (i_rsp_tuser[2] != want.take_valid)
                        report_mismatch("take_valid", i_rsp_tuser[2], want.take_valid);
                    if (i_rsp_tdata[15:0] != want.tag)
                        report_mismatch("take_tag", i_rsp_tdata[15:0], want.tag);
                    if (i_rsp_tdata[31:16] != want.key)
                        report_mismatch("take_key", i_rsp_tdata[31:16], want.key);
                    if (i_rsp_tuser[3] != want.from_timer)
                        report_mismatch("take_from_timer", i_rsp_tuser[3], want.from_timer);
                end
            end
            if (i_req_tvalid && i_req_tready) begin
                // drop the oldest prediction if the block runs too far ahead
                if (rsp_wr - rsp_rd >= RSP_DEPTH) begin
                    report_mismatch("requests outstanding", rsp_wr - rsp_rd, RSP_DEPTH - 1);
                    rsp_rd++;
                end
                expected_rsp[rsp_wr % RSP_DEPTH] = predict_response(i_req_tuser,
                                                                    i_req_tdata[15:0],
                                                                    i_req_tdata[31:16]);
                rsp_wr++;
            end
        end
        o_fail_count  <= fail_cnt;
        o_outstanding <= rsp_wr - rsp_rd;
    end

endmodule

[sim/priority_task_queue_dedup_test.sv]
module priority_task_queue_dedup_test
    import ptqd_pkg::*;
();

    localparam int ITEM_TARGET = 700;
    localparam int IDLE_LIMIT  = 1000;  // well above the longest touch scan, stalls far shorter
    localparam int END_PAUSE   = 40;

    // req_type codes the block ignores
    localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    typedef enum int {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_MOSTLY,   // ready at random, seven chances in eight
        RX_COMB      // fixed comb: four ready cycles out of eleven
    } t_rx_mode;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    int          fail_count;
    int          outstanding;
    int          sent_items    = 0;
    int          burst_left    = 0;
    int          idle_cycles   = 0;
    t_rx_mode    rx_mode       = RX_OPEN;
    int          rx_phase_left = 0;
    int          rx_tick       = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    priority_task_queue_dedup u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    ptqd_response_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_tvalid  (s_tvalid),
        .i_req_tready  (s_tready),
        .i_req_tdata   (s_tdata),
        .i_req_tuser   (s_tuser),
        .i_rsp_tvalid  (m_tvalid),
        .i_rsp_tready  (m_tready),
        .i_rsp_tdata   (m_tdata),
        .i_rsp_tuser   (m_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Response side: switch between stall patterns in phases of random length,
    // one of them with no stall at all.
    always @(posedge clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       <= t_rx_mode'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= ((rx_tick % 11) < 4);
        endcase
    end

    // Watchdog: end the run once nothing has moved on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("priority_task_queue_dedup regression: fail");
                $finish;
            end
        end
    end

    // Drive one request and hold it until the block takes it. Bursts of random
    // length are mostly separated by random gaps with valid low.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [TAG_W-1:0] tag,
                                input logic [KEY_W-1:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {key, tag};
        do @(posedge clk); while (!s_tready);
        // ignored codes do not count toward the stimulus length
        if (req <= REQ_STOP) sent_items++;
    endtask

    // Hold off the request side until every outstanding response has arrived.
    // The first edge is needed: the count seen right after an accepting edge
    // does not yet include that request.
    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Keys lean on a small pool and the extremes so duplicates are common.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return KEY_W'($urandom_range(0, 3));
            1:       return ($urandom_range(0, 1) == 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0:       return {TAG_W{1'b0}};
            1:       return {TAG_W{1'b1}};
            default: return TAG_W'($urandom);
        endcase
    endfunction

    // Running mix of submits and takes; keeps the queues wandering in depth.
    task automatic mixed_traffic(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) send_request(REQ_SUBMIT_TIMER, pick_tag(), pick_key());
            else if (pick < 7) send_request(REQ_SUBMIT_TOUCH, pick_tag(), pick_key());
            else send_request(REQ_TAKE, pick_tag(), pick_key());
        end
    endtask

    // Push past capacity, then hit the full queue with a pooled key (likely a
    // duplicate) and with a timer submit.
    task automatic fill_queues();
        int count;
        count = $urandom_range(32, 40);
        send_request(REQ_START, pick_tag(), pick_key());
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                send_request(REQ_SUBMIT_TIMER, pick_tag(), pick_key());
            end else if ($urandom_range(0, 3) == 0) begin
                send_request(REQ_SUBMIT_TOUCH, pick_tag(), KEY_W'($urandom_range(0, 3)));
            end else begin
                send_request(REQ_SUBMIT_TOUCH, pick_tag(), KEY_W'($urandom));
            end
        end
        send_request(REQ_SUBMIT_TOUCH, pick_tag(), KEY_W'($urandom_range(0, 3)));
        send_request(REQ_SUBMIT_TIMER, pick_tag(), pick_key());
    endtask

    task automatic drain_queues();
        int count;
        count = $urandom_range(8, 40);
        for (int i = 0; i < count; i++) send_request(REQ_TAKE, pick_tag(), pick_key());
    endtask

    // Stop (flushes), poke the stopped block, then start again.
    task automatic stop_cycle();
        int count;
        count = $urandom_range(1, 4);
        send_request(REQ_STOP, pick_tag(), pick_key());
        for (int i = 0; i < count; i++) begin
            send_request(REQ_W'($urandom_range(0, 4)), pick_tag(), pick_key());
        end
        send_request(REQ_START, pick_tag(), pick_key());
    endtask

    // Any code, any field, including the ignored codes.
    task automatic noise_burst();
        int count;
        count = $urandom_range(3, 10);
        for (int i = 0; i < count; i++) begin
            send_request(REQ_W'($urandom_range(0, 7)), TAG_W'($urandom), KEY_W'($urandom));
        end
        send_request(REQ_START, pick_tag(), pick_key());
    endtask

    initial begin
        int choice;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: requests while stopped, ignored codes, then priority order,
        // dedup and key release, extreme tags and keys, flush on stop.
        send_request(REQ_TAKE,         16'h1234, 16'h0000);
        send_request(REQ_SUBMIT_TIMER, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SUBMIT_TOUCH, 16'h0000, 16'h0001);
        send_request(REQ_STOP,         16'h0000, 16'h0000);
        send_request(REQ_RSVD_5,       16'hFFFF, 16'hFFFF);
        send_request(REQ_RSVD_6,       16'h0000, 16'h0000);
        send_request(REQ_RSVD_7,       16'hFFFF, 16'h0000);
        send_request(REQ_START,        16'h0000, 16'h0000);
        send_request(REQ_START,        16'hFFFF, 16'hFFFF);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_SUBMIT_TIMER, 16'h0000, 16'h0000);
        send_request(REQ_SUBMIT_TIMER, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SUBMIT_TOUCH, 16'hFFFF, 16'h0000);
        send_request(REQ_SUBMIT_TOUCH, 16'h0000, 16'hFFFF);
        send_request(REQ_SUBMIT_TOUCH, 16'h1234, 16'hFFFF);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_SUBMIT_TOUCH, 16'hAAAA, 16'hFFFF);
        send_request(REQ_SUBMIT_TIMER, 16'h5555, 16'h0000);
        send_request(REQ_STOP,         16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);
        send_request(REQ_START,        16'h0000, 16'h0000);
        send_request(REQ_TAKE,         16'h0000, 16'h0000);

        // Drain fully before going random.
        wait_for_responses();

        // Random: mostly well-formed traffic on a running block, with deep
        // fills and drains, stop/start cycles, noise and full drains mixed in.
        while (sent_items < ITEM_TARGET) begin
            choice = $urandom_range(0, 11);
            case (choice)
                0, 1, 2, 3: mixed_traffic($urandom_range(5, 30));
                4, 5:       fill_queues();
                6, 7:       drain_queues();
                8:          stop_cycle();
                9:          noise_burst();
                10:         wait_for_responses();
                default:    mixed_traffic($urandom_range(1, 4));
            endcase
        end

        // Let the last responses come home, then give the verdict.
        wait_for_responses();
        repeat (END_PAUSE) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("priority_task_queue_dedup regression: pass");
        end else begin
            $display("priority_task_queue_dedup regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ptqd_pkg.sv
rtl/ptqd_step_unit.sv
rtl/priority_task_queue_dedup.sv
sim/ptqd_response_checker.sv
sim/priority_task_queue_dedup_test.sv
